// ===== src/ss20_pkg.sv =====
// Shared types, constants and helper functions of the Salsa20 byte cipher.
package ss20_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int ROUND_STEPS = DOUBLE_ROUNDS * 8;
   localparam int STEP_W = $clog2(ROUND_STEPS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_NONCE = 3'd4;

   typedef logic [15:0][31:0] words_type;

   // One queued word with its keystream position already worked out.
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [5:0]  pos;
      logic        need_block;
      logic [63:0] counter;
   } work_type;

   typedef struct packed {
      logic        start;
      logic [63:0] counter;
   } core_req_type;

   typedef struct packed {
      logic      busy;
      logic      done;
      words_type block;
   } core_status_type;

   // Quarter-round word indices a, b, c, d: [half][lane][role].
   localparam logic [3:0] QIDX [2][4][4] = '{
      '{ '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
         '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11} },
      '{ '{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
         '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14} }
   };

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      begin
         d = {v, v} << n;
         return d[63:32];
      end
   endfunction

   function automatic words_type salsa_init(input logic [63:0] k0, input logic [63:0] k1,
                                            input logic [63:0] k2, input logic [63:0] k3,
                                            input logic [63:0] nonce,
                                            input logic [63:0] counter);
      words_type w;
      begin
         w[0] = SIGMA0;          w[1] = k0[31:0];        w[2] = k0[63:32];
         w[3] = k1[31:0];        w[4] = k1[63:32];       w[5] = SIGMA1;
         w[6] = nonce[31:0];     w[7] = nonce[63:32];    w[8] = counter[31:0];
         w[9] = counter[63:32];  w[10] = SIGMA2;         w[11] = k2[31:0];
         w[12] = k2[63:32];      w[13] = k3[31:0];       w[14] = k3[63:32];
         w[15] = SIGMA3;
         return w;
      end
   endfunction

endpackage

// ===== src/salsa20_stream_cipher_top.sv =====
// Within a block a pushed word passes the queue and the output register; the
// first word of each 64-byte block waits for the block core.
// Throughput: one word per cycle inside a block while the receiver keeps popping;
// at every block boundary and message start the word waits for the block core.
// Reset: synchronous, clears queue, position, counter and key/nonce registers.
// Top level: key/nonce registers and the front, queue, core and back units.
module salsa20_stream_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_message_start,
   input  logic        req_message_end,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_result_byte,
   output logic        rsp_result_end,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import ss20_pkg::*;

   logic [63:0]     key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff;
   logic            q_push, q_pop, q_full, q_empty;
   work_type        q_work, head;
   core_req_type    core_req;
   core_status_type core_st;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
         nonce_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY0: key0_ff <= csr_wdata;
            CSR_KEY1: key1_ff <= csr_wdata;
            CSR_KEY2: key2_ff <= csr_wdata;
            CSR_KEY3: key3_ff <= csr_wdata;
            CSR_NONCE: nonce_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ss20_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push),
      .req_data_byte(req_data_byte), .req_message_start(req_message_start),
      .req_message_end(req_message_end), .q_full(q_full),
      .q_push(q_push), .q_work(q_work)
   );

   ss20_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_work(q_work),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(head)
   );

   ss20_core u_core (
      .clock(clock), .reset(reset), .req(core_req), .key0(key0_ff),
      .key1(key1_ff), .key2(key2_ff), .key3(key3_ff), .nonce(nonce_ff),
      .status(core_st)
   );

   ss20_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .head(head),
      .q_pop(q_pop), .core_req(core_req), .core_st(core_st),
      .rsp_pop(pop), .rsp_empty(empty), .rsp_result_byte(rsp_result_byte),
      .rsp_result_end(rsp_result_end)
   );

   assign full = q_full;

endmodule

// ===== src/ss20_front.sv =====
// Front end: accepts words, tracks byte position and block counter.
module ss20_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_data_byte,
   input  logic              req_message_start,
   input  logic              req_message_end,
   input  logic              q_full,
   output logic              q_push,
   output ss20_pkg::work_type q_work
);
   import ss20_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [5:0]  pos_cur;
   logic [63:0] cnt_cur;
   logic        need;

   always_comb begin
      pos_cur = req_message_start ? 6'd0 : pos_ff;
      cnt_cur = req_message_start ? 64'd0 : cnt_ff;
      need = (pos_cur == 6'd0);
      q_push = req_push && !q_full;
      q_work.data = req_data_byte;
      q_work.last = req_message_end;
      q_work.pos = pos_cur;
      q_work.need_block = need;
      q_work.counter = cnt_cur;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (q_push) begin
         pos_in = pos_cur + 6'd1;
         cnt_in = need ? cnt_cur + 64'd1 : cnt_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cnt_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/ss20_queue.sv =====
// Short queue of classified words between front and back end.
module ss20_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ss20_pkg::work_type push_work,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output ss20_pkg::work_type head
);
   import ss20_pkg::*;

   work_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;
   logic                  do_pop;

   always_comb begin
      full = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      empty = (cnt_ff == '0);
      head = mem_ff[rd_ff];
      do_pop = pop && !empty;
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/ss20_core.sv =====
// Salsa20 block core: one quarter-round line per lane per cycle, then final add.
module ss20_core (
   input  logic                    clock,
   input  logic                    reset,
   input  ss20_pkg::core_req_type  req,
   input  logic [63:0]             key0,
   input  logic [63:0]             key1,
   input  logic [63:0]             key2,
   input  logic [63:0]             key3,
   input  logic [63:0]             nonce,
   output ss20_pkg::core_status_type status
);
   import ss20_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [63:0]       ctr_ff;
   words_type         x_ff, x_next, blk_ff;
   logic              done_ff, done_in;
   words_type         init_w;
   logic [1:0]        s;
   logic              half;
   logic [4:0]        rot;
   logic [3:0]        ti, i1, i2;

   always_comb begin
      init_w = salsa_init(key0, key1, key2, key3, nonce,
                          (state_ff == ST_IDLE) ? req.counter : ctr_ff);
      s = step_ff[1:0];
      half = step_ff[2];
      unique case (s)
         2'd0: rot = 5'd7;
         2'd1: rot = 5'd9;
         2'd2: rot = 5'd13;
         default: rot = 5'd18;
      endcase
      x_next = x_ff;
      for (int l = 0; l < 4; l++) begin
         ti = QIDX[half][l][s + 2'd1];
         i1 = QIDX[half][l][s];
         i2 = QIDX[half][l][s + 2'd3];
         x_next[ti] = x_ff[ti] ^ rotl32(x_ff[i1] + x_ff[i2], rot);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      done_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req.start) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            done_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.start) begin
         x_ff <= init_w;
         ctr_ff <= req.counter;
      end else if (state_ff == ST_ROUND) begin
         x_ff <= x_next;
      end
      if (state_ff == ST_FINAL) begin
         for (int i = 0; i < 16; i++) blk_ff[i] <= x_ff[i] + init_w[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = done_ff;
   assign status.block = blk_ff;

endmodule

// ===== src/ss20_back.sv =====
// Back end: requests blocks, holds keystream, XORs bytes into the output register.
module ss20_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  ss20_pkg::work_type        head,
   output logic                      q_pop,
   output ss20_pkg::core_req_type    core_req,
   input  ss20_pkg::core_status_type core_st,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic [7:0]                rsp_result_byte,
   output logic                      rsp_result_end
);
   import ss20_pkg::*;

   logic [63:0][7:0] ks_ff;
   logic             ready_ff, ready_in;
   logic             wait_ff, wait_in;
   logic             outv_ff, outv_in;
   logic [7:0]       byte_ff;
   logic             end_ff;
   logic             slot_free, have_ks;

   always_comb begin
      slot_free = !outv_ff || rsp_pop;
      have_ks = !head.need_block || ready_ff;
      q_pop = !q_empty && have_ks && slot_free;
      core_req.start = !q_empty && head.need_block && !ready_ff && !wait_ff
                       && !core_st.busy;
      core_req.counter = head.counter;
      wait_in = wait_ff;
      ready_in = ready_ff;
      if (core_req.start) wait_in = 1'b1;
      if (core_st.done) begin
         wait_in = 1'b0;
         ready_in = 1'b1;
      end
      // drop the block flag once its first word is used
      if (q_pop && head.need_block) ready_in = 1'b0;
      outv_in = q_pop ? 1'b1 : (rsp_pop ? 1'b0 : outv_ff);
   end

   always_ff @(posedge clock) begin
      if (core_st.done) ks_ff <= core_st.block;
      if (q_pop) begin
         byte_ff <= head.data ^ ks_ff[head.pos];
         end_ff <= head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         wait_ff <= 1'b0;
         outv_ff <= 1'b0;
      end else begin
         ready_ff <= ready_in;
         wait_ff <= wait_in;
         outv_ff <= outv_in;
      end
   end

   assign rsp_empty = !outv_ff;
   assign rsp_result_byte = byte_ff;
   assign rsp_result_end = end_ff;

endmodule

// ===== src/ss20_checker.sv =====
// Port-level checker for the Salsa20 byte cipher and its bind.
module ss20_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_result_byte,
   input logic        rsp_result_end
);

   // a waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result_byte) && $stable(rsp_result_end)))
      else $error("result word changed while waiting");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not clear after reset");

   // first word after reset needs a fresh block, so nothing comes out early
   a_first_block: assert property (@(posedge clock)
      (reset ##1 1'b1) |=> empty)
      else $error("result before first block was made");

endmodule

bind salsa20_stream_cipher_top ss20_checker u_ss20_checker (
   .clock(clock), .reset(reset), .req_push(req_push), .full(full),
   .empty(empty), .pop(pop), .rsp_result_byte(rsp_result_byte),
   .rsp_result_end(rsp_result_end)
);

// ===== tb/tb_top.sv =====
// Testbench for the Salsa20 byte cipher: directed and random byte streams checked per word.
`timescale 1ns / 1ps
module tb_top;
   import ss20_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        full;
   logic [7:0]  req_data_byte = 0;
   logic        req_message_start = 0;
   logic        req_message_end = 0;
   logic        empty;
   logic        pop = 0;
   logic [7:0]  rsp_result_byte;
   logic        rsp_result_end;
   logic        csr_write_en = 0;
   logic [2:0]  csr_index = CSR_KEY0;
   logic [63:0] csr_wdata = 0;

   salsa20_stream_cipher_top u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [63:0] key_reg [4];
   logic [63:0] nonce_reg;
   logic [31:0] ks_block [16];
   logic [5:0]  ks_pos;
   logic [63:0] blk_ctr;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       last;
   } cipher_word_t;
   cipher_word_t cipher_q [$];

   int mismatches = 0;
   int words_sent = 0;
   int words_checked = 0;
   int blocks_made = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit hold_off = 0;
   int stall_mode = 0;

   function automatic logic [31:0] rot_left(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic quarter(ref logic [31:0] x [16], input int a, b, c, d);
      x[b] ^= rot_left(x[a] + x[d], 7);
      x[c] ^= rot_left(x[b] + x[a], 9);
      x[d] ^= rot_left(x[c] + x[b], 13);
      x[a] ^= rot_left(x[d] + x[c], 18);
   endtask

   task automatic build_keystream_block();
      logic [31:0] seed [16];
      logic [31:0] x [16];
      seed[0] = SIGMA0;              seed[1] = key_reg[0][31:0];
      seed[2] = key_reg[0][63:32];   seed[3] = key_reg[1][31:0];
      seed[4] = key_reg[1][63:32];   seed[5] = SIGMA1;
      seed[6] = nonce_reg[31:0];     seed[7] = nonce_reg[63:32];
      seed[8] = blk_ctr[31:0];       seed[9] = blk_ctr[63:32];
      seed[10] = SIGMA2;             seed[11] = key_reg[2][31:0];
      seed[12] = key_reg[2][63:32];  seed[13] = key_reg[3][31:0];
      seed[14] = key_reg[3][63:32];  seed[15] = SIGMA3;
      x = seed;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         quarter(x, 0, 4, 8, 12);   quarter(x, 5, 9, 13, 1);
         quarter(x, 10, 14, 2, 6);  quarter(x, 15, 3, 7, 11);
         quarter(x, 0, 1, 2, 3);    quarter(x, 5, 6, 7, 4);
         quarter(x, 10, 11, 8, 9);  quarter(x, 15, 12, 13, 14);
      end
      for (int i = 0; i < 16; i++) ks_block[i] = x[i] + seed[i];
      blocks_made++;
   endtask

   task automatic predict_cipher_word(logic [7:0] d, logic st, logic en);
      cipher_word_t w;
      logic [31:0] kw;
      if (st) begin
         ks_pos = '0;
         blk_ctr = '0;
      end
      if (ks_pos == 6'd0) begin
         build_keystream_block();
         blk_ctr = blk_ctr + 64'd1;
      end
      kw = ks_block[ks_pos[5:2]];
      w.byte_val = d ^ kw[8*ks_pos[1:0] +: 8];
      w.last = en;
      cipher_q.push_back(w);
      ks_pos = ks_pos + 6'd1;
   endtask

   // send one word; prediction happens at the accepting edge
   task automatic send_word(logic [7:0] d, logic st, logic en);
      req_push <= 1;
      req_data_byte <= d;
      req_message_start <= st;
      req_message_end <= en;
      do @(posedge clock); while (full);
      predict_cipher_word(d, st, en);
      words_sent++;
      @(negedge clock);
      if ($urandom_range(0, 3) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic end_burst();
      req_push <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (cipher_q.size() != 0 && !timed_out) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] v);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      if (idx == CSR_NONCE) nonce_reg = v;
      else key_reg[idx[1:0]] = v;
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic load_key_nonce(logic [63:0] k0, k1, k2, k3, n);
      write_reg(CSR_KEY0, k0);
      write_reg(CSR_KEY1, k1);
      write_reg(CSR_KEY2, k2);
      write_reg(CSR_KEY3, k3);
      write_reg(CSR_NONCE, n);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // result checker
   always @(posedge clock) begin
      cipher_word_t exp_w;
      if (!reset && pop && !empty) begin
         words_checked++;
         if (cipher_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %02h", rsp_result_byte);
         end else begin
            exp_w = cipher_q.pop_front();
            if (rsp_result_byte !== exp_w.byte_val || rsp_result_end !== exp_w.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: exp %02h/%b got %02h/%b", words_checked,
                           exp_w.byte_val, exp_w.last, rsp_result_byte, rsp_result_end);
            end
         end
      end
   end

   // receiver stall pattern
   initial begin
      int tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_off) pop <= 0;
         else case (stall_mode)
            0: pop <= 1;
            1: pop <= ($urandom_range(0, 2) != 0);
            default: pop <= ((tick % 7) < 3);
         endcase
         if (tick % 300 == 0) stall_mode = $urandom_range(0, 2);
      end
   end

   // watchdog
   initial begin
      forever begin
         @(posedge clock);
         if ((req_push && !full) || (pop && !empty) || reset || csr_write_en
             || cipher_q.size() == 0)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            timed_out = 1;
            $display("watchdog: no progress");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic test_reset_defaults();
      // zero key, first word after reset needs no start flag
      for (int i = 0; i < 8; i++) send_word(8'h00, 0, i == 7);
      send_word(8'hff, 0, 0);
      end_burst();
      drain();
   endtask

   task automatic test_directed();
      load_key_nonce('1, '1, '1, '1, '1);
      send_word(8'h00, 1, 0);
      send_word(8'hff, 0, 0);
      send_word(8'h55, 0, 1);
      send_word(8'haa, 1, 0);
      // run across a block boundary
      for (int i = 0; i < 66; i++) send_word(i[7:0], 0, 0);
      // start flag mid-block
      send_word(8'h80, 1, 1);
      send_word(8'h01, 0, 0);
      end_burst();
      drain();
      load_key_nonce(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                     64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 64'h8000000000000001);
      for (int i = 0; i < 10; i++) send_word(8'($urandom), i == 0, i == 9);
      end_burst();
      drain();
   endtask

   task automatic test_config_mid_block();
      // new key applies from the next block
      send_word(8'h11, 1, 0);
      for (int i = 0; i < 20; i++) send_word(8'($urandom), 0, 0);
      end_burst();
      drain();
      write_reg(CSR_KEY2, rand64());
      write_reg(CSR_NONCE, rand64());
      for (int i = 0; i < 50; i++) send_word(8'($urandom), 0, i == 49);
      end_burst();
      drain();
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      fork
         begin
            for (int i = 0; i < 40; i++) send_word(8'($urandom), i == 0, 0);
            end_burst();
         end
         begin
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
      join
      drain();
   endtask

   task automatic test_random_messages(int target);
      int sent = 0;
      int len;
      while (sent < target) begin
         if (sent % 300 < 20) begin
            // rekey only with nothing in flight
            drain();
            load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64());
         end
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 70);
         for (int i = 0; i < len; i++) begin
            send_word(8'($urandom),
                      i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 60) == 0),
                      i == len - 1 ? 1'b1 : ($urandom_range(0, 20) == 0));
            sent++;
         end
         end_burst();
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) @(negedge clock);
         if ($urandom_range(0, 5) == 0) drain();
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      nonce_reg = '0;
      for (int i = 0; i < 16; i++) ks_block[i] = '0;
      ks_pos = '0;
      blk_ctr = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_reset_defaults();
      test_directed();
      test_config_mid_block();
      test_backpressure();
      test_random_messages(850);
      $display("run: %0d words sent, %0d checked, %0d keystream blocks, several keys",
               words_sent, words_checked, blocks_made);
      $display("covered start/end flags, block boundaries, mid-block rekey, full stall");
      if (mismatches == 0 && cipher_q.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== sim.f =====
src/ss20_pkg.sv
src/ss20_front.sv
src/ss20_queue.sv
src/ss20_core.sv
src/ss20_back.sv
src/salsa20_stream_cipher_top.sv
src/ss20_checker.sv
tb/tb_top.sv
